// File: hdl/assert_macros.svh
// Assertion macros shared by the index permuter RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under synchronous reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/ff1sp_pkg.sv
// Package of the FF1 index permuter: constants, types and helper functions.
// Used by the channel interfaces, the core and the top level.
package ff1sp_pkg;

   localparam int MAX_RETRIES    = 16;
   localparam int SPECK_ROUNDS   = 32;
   localparam int FEISTEL_ROUNDS = 10;
   localparam int MAC_BLOCKS     = 3;

   localparam int RND_W   = $clog2(SPECK_ROUNDS);
   localparam int FR_W    = $clog2(FEISTEL_ROUNDS);
   localparam int BLK_W   = $clog2(MAC_BLOCKS);
   localparam int TRY_W   = $clog2(MAX_RETRIES + 1);
   localparam int NBITS_W = 6;
   localparam int CSR_IDX_W = 8;

   // Fixed header bytes of the FF1 P block.
   localparam logic [7:0] FF1_VERSION  = 8'h01;
   localparam logic [7:0] FF1_METHOD   = 8'h02;
   localparam logic [7:0] FF1_RADIX    = 8'h0A;
   localparam logic [7:0] FF1_TWK_LEN  = 8'h04;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BLOCKS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 8'd2;

   typedef struct packed {
      logic [31:0] max_blocks;
      logic [63:0] key_low;
      logic [63:0] key_high;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NCALC,
      ST_SPLIT,
      ST_LOAD,
      ST_SPECK,
      ST_MIX,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Mask of the m low bits, m at most 32.
   function automatic logic [31:0] low_mask(input logic [NBITS_W-1:0] m);
      low_mask = 32'((33'd1 << m) - 33'd1);
   endfunction

   // Byte reversal of a 32-bit word.
   function automatic logic [31:0] byte_swap(input logic [31:0] w);
      byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// File: hdl/ff1sp_channels.sv
// Valid/ready channel interfaces of the FF1 index permuter.
// Depends on ff1sp_pkg for the register index width.
interface ff1sp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] index;
   logic [31:0] tweak;
   modport source (output valid, index, tweak, input ready);
   modport sink (input valid, index, tweak, output ready);
endinterface

interface ff1sp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] permuted_index;
   logic        gave_up;
   modport source (output valid, permuted_index, gave_up, input ready);
   modport sink (input valid, permuted_index, gave_up, output ready);
endinterface

interface ff1sp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ff1sp_pkg::CSR_IDX_W-1:0] index;
   logic [63:0]                     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ff1sp_round.sv
// One Speck128 round: x = (x >>> 8) + y ^ k, y = (y <<< 3) ^ x.
// Used by the data path and the on-the-fly key schedule. No dependencies.
module ff1sp_round (
   input  logic [63:0] x_in_val,
   input  logic [63:0] y_in_val,
   input  logic [63:0] key,
   output logic [63:0] x_out,
   output logic [63:0] y_out
);
   logic [63:0] x_rot;
   logic [63:0] x_new;

   // Rotate, add, key mix, then fold into y.
   assign x_rot = {x_in_val[7:0], x_in_val[63:8]};
   assign x_new = (x_rot + y_in_val) ^ key;
   assign x_out = x_new;
   assign y_out = {y_in_val[60:0], y_in_val[63:61]} ^ x_new;
endmodule

// File: hdl/ff1sp_core.sv
// Sequencer and datapath of the FF1 index permuter around two Speck rounds.
// Depends on ff1sp_pkg, ff1sp_channels, ff1sp_round and assert_macros.svh.
`include "assert_macros.svh"
module ff1sp_core (
   input  logic                clock,
   input  logic                reset,
   input  ff1sp_pkg::cfg_type  cfg,
   ff1sp_req_if.sink           req_if,
   ff1sp_rsp_if.source         rsp_if
);
   ff1sp_pkg::state_type state_ff, state_in;

   logic [31:0] idx_ff, idx_in;
   logic [31:0] tweak_ff, tweak_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] t_ff, t_in;
   logic [ff1sp_pkg::NBITS_W-1:0] n_ff, n_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] l_ff, l_in;
   logic [ff1sp_pkg::RND_W-1:0] r_ff, r_in;
   logic [ff1sp_pkg::BLK_W-1:0] blk_ff, blk_in;
   logic [ff1sp_pkg::FR_W-1:0]  fr_ff, fr_in;
   logic [ff1sp_pkg::TRY_W-1:0] tries_ff, tries_in;
   logic [31:0] perm_ff, perm_in;
   logic        gave_ff, gave_in;

   logic [ff1sp_pkg::NBITS_W-1:0] u_half;
   logic [ff1sp_pkg::NBITS_W-1:0] v_half;
   logic [ff1sp_pkg::NBITS_W-1:0] m_half;
   logic [63:0] hi_rnd, lo_rnd, l_rnd, k_rnd;
   logic [63:0] blk_lo, blk_hi;
   logic [31:0] n_word, y_val, c_val, walked;

   // Data round and key schedule round, advanced in lockstep.
   ff1sp_round u_data_round (
      .x_in_val (hi_ff), .y_in_val (lo_ff), .key (k_ff),
      .x_out (hi_rnd), .y_out (lo_rnd)
   );
   ff1sp_round u_key_round (
      .x_in_val (l_ff), .y_in_val (k_ff), .key (64'(r_ff)),
      .x_out (l_rnd), .y_out (k_rnd)
   );

   // Half widths and the per-round modulus.
   assign u_half = n_ff >> 1;
   assign v_half = n_ff - u_half;
   assign m_half = fr_ff[0] ? v_half : u_half;
   assign n_word = 32'(n_ff);
   assign y_val  = ff1sp_pkg::byte_swap(lo_ff[31:0]);
   assign c_val  = (a_ff + y_val) & ff1sp_pkg::low_mask(m_half);
   assign walked = (a_ff << v_half) | b_ff;

   // Message block words of P || Q, loaded little-endian.
   always_comb begin
      case (blk_ff)
         2'd0: begin
            blk_lo = {n_word[15:8], n_word[23:16], n_word[31:24], ff1sp_pkg::FF1_RADIX,
                      ff1sp_pkg::FF1_METHOD, 8'h00, 8'h00, ff1sp_pkg::FF1_VERSION};
            blk_hi = {32'h0, ff1sp_pkg::FF1_TWK_LEN, 8'h00, 8'h00, n_word[7:0]};
         end
         2'd1: begin
            blk_lo = {32'h0, ff1sp_pkg::byte_swap(tweak_ff)};
            blk_hi = {8'(fr_ff), 56'h0};
         end
         2'd2: begin
            blk_lo = {32'h0, ff1sp_pkg::byte_swap(b_ff)};
            blk_hi = 64'h0;
         end
         default: begin
            blk_lo = 64'h0;
            blk_hi = 64'h0;
         end
      endcase
   end

   // State register and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ff1sp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff   <= idx_in;
      tweak_ff <= tweak_in;
      cur_ff   <= cur_in;
      t_ff     <= t_in;
      n_ff     <= n_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      k_ff     <= k_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      blk_ff   <= blk_in;
      fr_ff    <= fr_in;
      tries_ff <= tries_in;
      perm_ff  <= perm_in;
      gave_ff  <= gave_in;
   end

   // Next state and datapath control.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      tweak_in = tweak_ff;
      cur_in   = cur_ff;
      t_in     = t_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      k_in     = k_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      blk_in   = blk_ff;
      fr_in    = fr_ff;
      tries_in = tries_ff;
      perm_in  = perm_ff;
      gave_in  = gave_ff;
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      case (state_ff)
         ff1sp_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               idx_in   = req_if.index;
               cur_in   = req_if.index;
               tweak_in = req_if.tweak;
               tries_in = '0;
               gave_in  = 1'b0;
               perm_in  = req_if.index;
               t_in     = cfg.max_blocks - 32'd1;
               n_in     = '0;
               // Out-of-domain index or trivial domain passes through.
               if (req_if.index >= cfg.max_blocks || cfg.max_blocks <= 32'd1) begin
                  state_in = ff1sp_pkg::ST_DONE;
               end else begin
                  state_in = ff1sp_pkg::ST_NCALC;
               end
            end
         end
         ff1sp_pkg::ST_NCALC: begin
            // Bit length of max_blocks - 1, one bit a cycle.
            if (t_ff != 32'd0) begin
               t_in = t_ff >> 1;
               n_in = n_ff + 1'b1;
            end else begin
               state_in = ff1sp_pkg::ST_SPLIT;
            end
         end
         ff1sp_pkg::ST_SPLIT: begin
            a_in     = cur_ff >> v_half;
            b_in     = cur_ff & ff1sp_pkg::low_mask(v_half);
            fr_in    = '0;
            blk_in   = '0;
            state_in = ff1sp_pkg::ST_LOAD;
         end
         ff1sp_pkg::ST_LOAD: begin
            // Chain the next block in; the first block starts from a zero IV.
            if (blk_ff == '0) begin
               lo_in = blk_lo;
               hi_in = blk_hi;
            end else begin
               lo_in = lo_ff ^ blk_lo;
               hi_in = hi_ff ^ blk_hi;
            end
            k_in     = cfg.key_low;
            l_in     = cfg.key_high;
            r_in     = '0;
            state_in = ff1sp_pkg::ST_SPECK;
         end
         ff1sp_pkg::ST_SPECK: begin
            hi_in = hi_rnd;
            lo_in = lo_rnd;
            k_in  = k_rnd;
            l_in  = l_rnd;
            r_in  = r_ff + 1'b1;
            if (r_ff == ff1sp_pkg::RND_W'(ff1sp_pkg::SPECK_ROUNDS - 1)) begin
               if (blk_ff == ff1sp_pkg::BLK_W'(ff1sp_pkg::MAC_BLOCKS - 1)) begin
                  state_in = ff1sp_pkg::ST_MIX;
               end else begin
                  blk_in   = blk_ff + 1'b1;
                  state_in = ff1sp_pkg::ST_LOAD;
               end
            end
         end
         ff1sp_pkg::ST_MIX: begin
            // Feistel update of the two halves.
            a_in   = b_ff;
            b_in   = c_val;
            blk_in = '0;
            if (fr_ff == ff1sp_pkg::FR_W'(ff1sp_pkg::FEISTEL_ROUNDS - 1)) begin
               state_in = ff1sp_pkg::ST_CHECK;
            end else begin
               fr_in    = fr_ff + 1'b1;
               state_in = ff1sp_pkg::ST_LOAD;
            end
         end
         ff1sp_pkg::ST_CHECK: begin
            // Cycle walking: retry with the next tweak while out of range.
            if (walked < cfg.max_blocks) begin
               perm_in  = walked;
               state_in = ff1sp_pkg::ST_DONE;
            end else if (tries_ff == ff1sp_pkg::TRY_W'(ff1sp_pkg::MAX_RETRIES)) begin
               perm_in  = idx_ff;
               gave_in  = 1'b1;
               state_in = ff1sp_pkg::ST_DONE;
            end else begin
               tweak_in = tweak_ff + 32'd1;
               tries_in = tries_ff + 1'b1;
               cur_in   = walked;
               state_in = ff1sp_pkg::ST_SPLIT;
            end
         end
         ff1sp_pkg::ST_DONE: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               state_in = ff1sp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ff1sp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_if.permuted_index = perm_ff;
   assign rsp_if.gave_up        = gave_ff;

   // Checks on the sequencer.
   `ASSERT_IMPLIES(a_one_item, clock, reset, rsp_if.valid, !req_if.ready)
   `ASSERT_IMPLIES(a_gave_up_index, clock, reset, rsp_if.valid && rsp_if.gave_up,
      rsp_if.permuted_index == idx_ff)
   `ASSERT_IMPLIES(a_width_range, clock, reset, state_ff == ff1sp_pkg::ST_SPLIT,
      n_ff >= 6'd1 && n_ff <= 6'd32)
   `ASSERT_NEXT(a_single_result, clock, reset, rsp_if.valid && rsp_if.ready, !rsp_if.valid)
endmodule

// File: hdl/ff1sp_csr.sv
// Configuration registers of the FF1 index permuter.
// Depends on ff1sp_pkg and ff1sp_channels.
module ff1sp_csr (
   input  logic               clock,
   input  logic               reset,
   ff1sp_csr_if.sink          csr_if,
   output ff1sp_pkg::cfg_type cfg
);
   ff1sp_pkg::cfg_type cfg_ff, cfg_in;

   // Register file; writes to unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            ff1sp_pkg::CSR_MAX_BLOCKS: cfg_in.max_blocks = csr_if.data[31:0];
            ff1sp_pkg::CSR_KEY_LOW:    cfg_in.key_low    = csr_if.data;
            ff1sp_pkg::CSR_KEY_HIGH:   cfg_in.key_high   = csr_if.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;
endmodule

// File: hdl/ff1_speck_index_permuter_unit.sv
// Top level of the FF1 index permuter over Speck128/128.
// Depends on ff1sp_pkg, ff1sp_channels, ff1sp_csr and ff1sp_core.
//
// Maps each index below max_blocks through a keyed FF1 permutation of
// 0..max_blocks-1 and returns one result item per input item. The block takes
// one item at a time: req ready is low from acceptance until the result item
// is taken. An item that passes through has its result valid in the cycle
// after acceptance. A permuted item first has the bit count of max_blocks - 1
// found, then goes through up to 17 walks. Each walk splits the index, runs 10
// Feistel rounds of 3 Speck blocks (each a load and 32 Speck rounds, data and
// key schedule round units in lockstep) with a mix per Feistel round, and then
// checks the range; its result is valid in the cycle after the last walk.
// The user must write configuration only while the block is idle; the block itself does not enforce this.
module ff1_speck_index_permuter_unit (
   input  logic         clock,
   input  logic         reset,
   ff1sp_req_if.sink    req_if,
   ff1sp_rsp_if.source  rsp_if,
   ff1sp_csr_if.sink    csr_if
);
   ff1sp_pkg::cfg_type cfg;

   ff1sp_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   ff1sp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );
endmodule
